@@ src/dsf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_pkg
// Types, line codes and step helpers shared by the packet framer modules.
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam logic [7:0] START_BYTE  = 8'h0F;
    localparam logic [7:0] END_BYTE    = 8'h04;
    localparam logic [7:0] ESCAPE_BYTE = 8'h05;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       packet_first;
        logic       packet_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_end;
    } t_out_item;

    // classified item handed from the front to the back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] check;
        logic       first;
        logic       last;
        logic       esc_data;
        logic       esc_check;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START0,
        ST_START1,
        ST_DATA_ESC,
        ST_DATA,
        ST_CHK_ESC,
        ST_CHK,
        ST_END
    } t_step;

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == START_BYTE) || (b == END_BYTE) || (b == ESCAPE_BYTE);
    endfunction

    function automatic t_step data_step(input t_cmd c);
        return c.esc_data ? ST_DATA_ESC : ST_DATA;
    endfunction

    function automatic t_step first_step(input t_cmd c);
        return c.first ? ST_START0 : data_step(c);
    endfunction

    // true when this step puts out the last line byte of the item
    function automatic logic step_final(input t_step s, input t_cmd c);
        logic fin;
        fin = 1'b0;
        unique case (s)
            ST_DATA: fin = !c.last;
            ST_END:  fin = 1'b1;
            default: fin = 1'b0;
        endcase
        return fin;
    endfunction

    function automatic t_step step_after(input t_step s, input t_cmd c);
        t_step nxt;
        nxt = ST_IDLE;
        unique case (s)
            ST_START0:   nxt = ST_START1;
            ST_START1:   nxt = data_step(c);
            ST_DATA_ESC: nxt = ST_DATA;
            ST_DATA:     nxt = c.esc_check ? ST_CHK_ESC : ST_CHK;
            ST_CHK_ESC:  nxt = ST_CHK;
            ST_CHK:      nxt = ST_END;
            default:     nxt = ST_IDLE;
        endcase
        return nxt;
    endfunction

    function automatic logic [7:0] step_byte(input t_step s, input t_cmd c);
        logic [7:0] b;
        b = 8'h00;
        case (s) inside
            ST_START0, ST_START1:    b = START_BYTE;
            ST_DATA_ESC, ST_CHK_ESC: b = ESCAPE_BYTE;
            ST_DATA:                 b = c.data;
            ST_CHK:                  b = c.check;
            ST_END:                  b = END_BYTE;
            default:                 b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ src/dle_stuffed_packet_framer.sv @@
`timescale 1ns / 1ps
// first line byte of an item passes the queue, item register and output register
// throughput: one line byte per cycle when not stalled; an item causes 1 to 7
// line bytes, so unescaped mid-packet bytes run at one item per cycle
// the output register and the back-end sequencer set that pace
// reset: synchronous active low, clears the running sum, queue and output
// ----------------------------------------------------------------------------
// dle_stuffed_packet_framer
// Byte-stuffing packet framer with start/end bytes and a checksum trailer.
// ----------------------------------------------------------------------------
module dle_stuffed_packet_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dsf_pkg::t_in_item  i_in,
    output logic               o_stall,
    output logic               o_valid,
    output dsf_pkg::t_out_item o_out,
    input  logic               i_stall
);

    logic          push;
    logic          full;
    logic          pop;
    logic          avail;
    dsf_pkg::t_cmd front_cmd;
    dsf_pkg::t_cmd queue_cmd;

    dsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_stall (o_stall),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    dsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_cmd   (queue_cmd)
    );

    dsf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

endmodule

@@ src/dsf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_front
// Accepts payload bytes, keeps the running sum and classifies each byte.
// ----------------------------------------------------------------------------
module dsf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dsf_pkg::t_in_item i_in,
    output logic              o_stall,
    input  logic              i_full,
    output logic              o_push,
    output dsf_pkg::t_cmd     o_cmd
);

    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [7:0] sum_base;
    logic [7:0] new_sum;
    logic [7:0] check;

    assign o_stall  = i_full;
    assign o_push   = i_valid && !i_full;

    // a first byte starts the sum afresh
    assign sum_base = i_in.packet_first ? 8'h00 : r_sum;
    assign new_sum  = sum_base + i_in.payload_byte;
    assign check    = 8'h00 - new_sum;

    always_comb begin
        o_cmd.data      = i_in.payload_byte;
        o_cmd.check     = check;
        o_cmd.first     = i_in.packet_first;
        o_cmd.last      = i_in.packet_last;
        o_cmd.esc_data  = dsf_pkg::needs_escape(i_in.payload_byte);
        o_cmd.esc_check = dsf_pkg::needs_escape(check);
    end

    always_comb begin
        n_sum = r_sum;
        if (o_push) begin
            n_sum = i_in.packet_last ? 8'h00 : new_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 8'h00;
        end else begin
            r_sum <= n_sum;
        end
    end

endmodule

@@ src/dsf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module dsf_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dsf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_avail,
    output dsf_pkg::t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    dsf_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_avail = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/dsf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_back
// Steps through the line bytes of each queued item into an output register.
// ----------------------------------------------------------------------------
module dsf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  dsf_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    output dsf_pkg::t_out_item o_out,
    input  logic               i_stall
);

    dsf_pkg::t_step     r_step;
    dsf_pkg::t_step     n_step;
    dsf_pkg::t_cmd      r_cur;
    dsf_pkg::t_cmd      n_cur;
    logic               r_out_valid;
    logic               n_out_valid;
    dsf_pkg::t_out_item r_out;
    dsf_pkg::t_out_item n_out;
    logic               load;
    logic               fin;

    assign load    = !r_out_valid || !i_stall;
    assign fin     = dsf_pkg::step_final(r_step, r_cur);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    always_comb begin
        n_step      = r_step;
        n_cur       = r_cur;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        o_pop       = 1'b0;
        if (r_step == dsf_pkg::ST_IDLE) begin
            if (i_avail) begin
                o_pop  = 1'b1;
                n_cur  = i_cmd;
                n_step = dsf_pkg::first_step(i_cmd);
            end
        end else if (load) begin
            n_out_valid     = 1'b1;
            n_out.line_byte = dsf_pkg::step_byte(r_step, r_cur);
            n_out.run_end   = fin;
            if (fin) begin
                // take the next item straight away so items run without a gap
                if (i_avail) begin
                    o_pop  = 1'b1;
                    n_cur  = i_cmd;
                    n_step = dsf_pkg::first_step(i_cmd);
                end else begin
                    n_step = dsf_pkg::ST_IDLE;
                end
            end else begin
                n_step = dsf_pkg::step_after(r_step, r_cur);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= dsf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

endmodule

@@ dv/dle_stuffed_packet_framer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_stuffed_packet_framer_test
// Self-checking bench for the byte-stuffing packet framer. Payload bytes go in
// as first/last marked transfers; a line framer model predicts start bytes,
// escapes, the negated checksum trailer and the end byte, and every line byte
// out is compared in order against it under random idling on both sides.
// ----------------------------------------------------------------------------
module dle_stuffed_packet_framer_test;

    localparam int RANDOM_ITEMS = 450;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES = 12;

    // predicts line bytes per payload transfer and checks them as they leave
    class line_framer_board;
        dsf_pkg::t_out_item line_q[$];
        logic [7:0]         sum_acc;
        int                 mismatches;
        int                 checked;
        int                 escapes;
        int                 packets;

        function new();
            sum_acc    = 8'h00;
            mismatches = 0;
            checked    = 0;
            escapes    = 0;
            packets    = 0;
        endfunction

        function int pending();
            return line_q.size();
        endfunction

        function void push_line(logic [7:0] b);
            dsf_pkg::t_out_item o;
            o.line_byte = b;
            o.run_end   = 1'b0;
            line_q.push_back(o);
        endfunction

        function void push_stuffed(logic [7:0] b);
            if (b == dsf_pkg::START_BYTE || b == dsf_pkg::END_BYTE
                    || b == dsf_pkg::ESCAPE_BYTE) begin
                push_line(dsf_pkg::ESCAPE_BYTE);
                escapes++;
            end
            push_line(b);
        endfunction

        function void note_input(dsf_pkg::t_in_item it);
            logic [7:0] trailer;
            if (it.packet_first) begin
                sum_acc = 8'h00;
                push_line(dsf_pkg::START_BYTE);
                push_line(dsf_pkg::START_BYTE);
            end
            sum_acc = sum_acc + it.payload_byte;
            push_stuffed(it.payload_byte);
            if (it.packet_last) begin
                trailer = 8'h00 - sum_acc;
                push_stuffed(trailer);
                push_line(dsf_pkg::END_BYTE);
                sum_acc = 8'h00;
                packets++;
            end
            line_q[line_q.size() - 1].run_end = 1'b1;
        endfunction

        function void flag(string what);
            if (mismatches < 10)
                $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endfunction

        function void check_line(dsf_pkg::t_out_item got);
            dsf_pkg::t_out_item want;
            checked++;
            if (line_q.size() == 0) begin
                flag($sformatf("unexpected line byte %02h run_end %0b",
                               got.line_byte, got.run_end));
                return;
            end
            want = line_q.pop_front();
            if (want.line_byte !== got.line_byte || want.run_end !== got.run_end)
                flag($sformatf("line_byte exp %02h got %02h, run_end exp %0b got %0b",
                               want.line_byte, got.line_byte,
                               want.run_end, got.run_end));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    dsf_pkg::t_in_item  i_in;
    logic               o_stall;
    logic               o_valid;
    dsf_pkg::t_out_item o_out;
    logic               i_stall;

    line_framer_board board = new();

    bit steady = 1'b0;
    int in_count = 0;
    int rand_sent = 0;
    int quiet_cycles = 0;

    dle_stuffed_packet_framer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiving side: check each line byte transfer, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_line(o_out);
        if (!steady && $urandom_range(99) < 30)
            i_stall <= 1'b1;
        else
            i_stall <= 1'b0;
    end

    // cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic dsf_pkg::t_in_item make_item(logic [7:0] b, logic first,
                                                    logic last);
        dsf_pkg::t_in_item it;
        it.payload_byte = b;
        it.packet_first = first;
        it.packet_last  = last;
        return it;
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(11))
            0:       b = dsf_pkg::START_BYTE;
            1:       b = dsf_pkg::END_BYTE;
            2:       b = dsf_pkg::ESCAPE_BYTE;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    // holds valid high across back-to-back transfers
    task automatic send_item(dsf_pkg::t_in_item it);
        i_valid <= 1'b1;
        i_in    <= it;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.note_input(it);
        in_count++;
    endtask

    task automatic sender_gap();
        if (!steady && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            i_in    <= dsf_pkg::t_in_item'(10'($urandom_range(1023)));
            repeat ($urandom_range(1, 4))
                @(posedge i_clk);
        end
    endtask

    task automatic drain_lines();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_directed();
        dsf_pkg::t_in_item seq[$];
        seq.push_back(make_item(8'h00, 1'b1, 1'b1));
        seq.push_back(make_item(8'hFF, 1'b1, 1'b1));
        // escaped payload and a trailer that is itself the escape code
        seq.push_back(make_item(dsf_pkg::START_BYTE, 1'b1, 1'b0));
        seq.push_back(make_item(dsf_pkg::END_BYTE, 1'b0, 1'b0));
        seq.push_back(make_item(dsf_pkg::ESCAPE_BYTE, 1'b0, 1'b0));
        seq.push_back(make_item(8'hE3, 1'b0, 1'b1));
        seq.push_back(make_item(dsf_pkg::END_BYTE, 1'b1, 1'b1));
        seq.push_back(make_item(8'hF1, 1'b1, 1'b1));
        seq.push_back(make_item(dsf_pkg::START_BYTE, 1'b1, 1'b1));
        // bytes with no packet open
        seq.push_back(make_item(8'h80, 1'b0, 1'b0));
        seq.push_back(make_item(8'h7F, 1'b0, 1'b0));
        seq.push_back(make_item(8'h01, 1'b0, 1'b1));
        // sum wraps, trailer lands on the end code
        seq.push_back(make_item(8'hFF, 1'b1, 1'b0));
        seq.push_back(make_item(8'hFF, 1'b0, 1'b0));
        seq.push_back(make_item(8'hFF, 1'b0, 1'b0));
        seq.push_back(make_item(8'hFF, 1'b0, 1'b1));
        // a fresh first mark in mid packet restarts the sum
        seq.push_back(make_item(8'h10, 1'b1, 1'b0));
        seq.push_back(make_item(8'h20, 1'b1, 1'b0));
        seq.push_back(make_item(8'h30, 1'b0, 1'b1));
        seq.push_back(make_item(8'hAA, 1'b1, 1'b0));
        seq.push_back(make_item(8'h55, 1'b0, 1'b1));
        foreach (seq[k]) begin
            send_item(seq[k]);
            sender_gap();
        end
    endtask

    task automatic run_random();
        int plen;
        int next_drain;
        next_drain = 120;
        while (rand_sent < RANDOM_ITEMS) begin
            steady = (rand_sent >= 180 && rand_sent < 290);
            if ($urandom_range(99) < 12) begin
                // loose byte with arbitrary marks
                send_item(make_item(pick_byte(), 1'($urandom_range(1)),
                                    1'($urandom_range(1))));
                rand_sent++;
                sender_gap();
            end else begin
                plen = ($urandom_range(99) < 8) ? $urandom_range(16, 28)
                                                : $urandom_range(1, 8);
                for (int k = 0; k < plen; k++) begin
                    send_item(make_item(pick_byte(), k == 0, k == plen - 1));
                    rand_sent++;
                    sender_gap();
                end
            end
            if (rand_sent >= next_drain) begin
                drain_lines();
                next_drain += 120;
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in    <= '0;
        repeat (8)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain_lines();
        run_random();
        drain_lines();
        repeat (TAIL_CYCLES)
            @(posedge i_clk);

        if (board.pending() != 0)
            board.flag($sformatf("%0d line bytes never arrived", board.pending()));
        $display("covered %0d payload transfers, %0d packets closed, %0d line bytes checked",
                 in_count, board.packets, board.checked);
        $display("escape sequences predicted %0d, mismatches %0d",
                 board.escapes, board.mismatches);
        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
